// ----- rtl/lse_pkg.sv -----
// Shared types and constants for the LSB steganography extractor.
`timescale 1ns / 1ps

package lse_pkg;

   // Bits in the big-endian length header and in one message byte.
   localparam int unsigned HEADER_BITS = 32;
   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned LEN_W       = 32;
   localparam int unsigned HCNT_W      = 6;
   localparam int unsigned BCNT_W      = 3;

   // Extraction phase; the fourth code never arises and is handled as done.
   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_MESSAGE = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_BYTE      = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_HDR_SHORT = 2'd2,
      ST_TRUNC     = 2'd3
   } status_type;

   // One queue entry: what one pixel produced, at most a data word and an error word.
   typedef struct packed {
      logic             has_data;
      logic [7:0]       data_byte;
      status_type       data_status;
      logic             data_last;
      logic             has_err;
      status_type       err_status;
      logic [LEN_W-1:0] length;
   } entry_type;

   // Write side of the queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Read side of the queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ----- rtl/lse_req_if.sv -----
// Pixel channel: valid/ready handshake with three color channels and an end flag.
`timescale 1ns / 1ps

interface lse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] channel_0;
   logic [7:0] channel_1;
   logic [7:0] channel_2;
   logic       end_of_image;

   modport source (output valid, output channel_0, output channel_1, output channel_2,
                   output end_of_image, input ready);
   modport sink (input valid, input channel_0, input channel_1, input channel_2,
                 input end_of_image, output ready);
endinterface

// ----- rtl/lse_rsp_if.sv -----
// Result channel: valid/ready handshake carrying recovered bytes and status.
`timescale 1ns / 1ps

interface lse_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  message_byte;
   logic [1:0]  status;
   logic [31:0] message_length;
   logic        last;

   modport source (output valid, output message_byte, output status,
                   output message_length, output last, input ready);
   modport sink (input valid, input message_byte, input status,
                 input message_length, input last, output ready);
endinterface

// ----- rtl/lse_front.sv -----
// Front end: takes pixels, runs the bit-stream decoder and forms queue entries.
`timescale 1ns / 1ps

module lse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_channel_0,
   input  logic [7:0]        in_channel_1,
   input  logic [7:0]        in_channel_2,
   input  logic              in_end_of_image,
   input  logic              space_ok,
   output logic              in_ready,
   output lse_pkg::push_type push
);

   lse_pkg::phase_type             phase_ff, phase_in;
   logic [lse_pkg::LEN_W-1:0]      hdr_shift_ff, hdr_shift_in;
   logic [lse_pkg::HCNT_W-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [lse_pkg::LEN_W-1:0]      remain_ff, remain_in;
   logic [lse_pkg::LEN_W-1:0]      length_ff, length_in;
   logic [7:0]                     acc_ff, acc_in;
   logic [lse_pkg::BCNT_W-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [2:0]                     bits;
   logic                           accept;
   lse_pkg::entry_type             entry;

   assign in_ready = space_ok;
   assign accept   = in_valid && space_ok;

   // Channel 0 carries the first stream bit.
   assign bits = {in_channel_2[0], in_channel_1[0], in_channel_0[0]};

   // Decoder state registers; they move only when a pixel is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lse_pkg::PH_HEADER;
         hdr_shift_ff <= '0;
         hdr_cnt_ff   <= '0;
         remain_ff    <= '0;
         length_ff    <= '0;
         acc_ff       <= '0;
         byte_cnt_ff  <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hdr_shift_ff <= hdr_shift_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         remain_ff    <= remain_in;
         length_ff    <= length_in;
         acc_ff       <= acc_in;
         byte_cnt_ff  <= byte_cnt_in;
      end
   end

   // Walk the three bits of the pixel, then handle the end of the image.
   always_comb begin
      phase_in     = phase_ff;
      hdr_shift_in = hdr_shift_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      remain_in    = remain_ff;
      length_in    = length_ff;
      acc_in       = acc_ff;
      byte_cnt_in  = byte_cnt_ff;
      entry        = '0;

      for (int i = 0; i < 3; i++) begin
         unique case (phase_in)
            lse_pkg::PH_HEADER: begin
               hdr_shift_in = {hdr_shift_in[lse_pkg::LEN_W-2:0], bits[2'(i)]};
               hdr_cnt_in   = hdr_cnt_in + 1'b1;
               if (hdr_cnt_in == lse_pkg::HCNT_W'(lse_pkg::HEADER_BITS)) begin
                  length_in   = hdr_shift_in;
                  remain_in   = hdr_shift_in;
                  acc_in      = '0;
                  byte_cnt_in = '0;
                  if (hdr_shift_in == '0) begin
                     // An empty message ends the image's work right here.
                     phase_in          = lse_pkg::PH_DONE;
                     entry.has_data    = 1'b1;
                     entry.data_byte   = '0;
                     entry.data_status = lse_pkg::ST_EMPTY;
                     entry.data_last   = 1'b1;
                     entry.length      = '0;
                  end else begin
                     phase_in = lse_pkg::PH_MESSAGE;
                  end
               end
            end
            lse_pkg::PH_MESSAGE: begin
               acc_in = {acc_in[6:0], bits[2'(i)]};
               if (byte_cnt_in == lse_pkg::BCNT_W'(lse_pkg::BYTE_BITS - 1)) begin
                  entry.has_data    = 1'b1;
                  entry.data_byte   = acc_in;
                  entry.data_status = lse_pkg::ST_BYTE;
                  entry.data_last   = (remain_in == lse_pkg::LEN_W'(1));
                  entry.length      = length_in;
                  acc_in            = '0;
                  byte_cnt_in       = '0;
                  remain_in         = remain_in - 1'b1;
                  if (remain_in == '0) begin
                     phase_in = lse_pkg::PH_DONE;
                  end
               end else begin
                  byte_cnt_in = byte_cnt_in + 1'b1;
               end
            end
            default: begin
               // Done: bits after the message are dropped.
            end
         endcase
      end

      if (in_end_of_image) begin
         if (phase_in == lse_pkg::PH_HEADER) begin
            entry.has_err    = 1'b1;
            entry.err_status = lse_pkg::ST_HDR_SHORT;
            entry.length     = '0;
         end else if (phase_in == lse_pkg::PH_MESSAGE) begin
            entry.has_err    = 1'b1;
            entry.err_status = lse_pkg::ST_TRUNC;
            entry.length     = length_in;
         end
         phase_in     = lse_pkg::PH_HEADER;
         hdr_shift_in = '0;
         hdr_cnt_in   = '0;
         remain_in    = '0;
         length_in    = '0;
         acc_in       = '0;
         byte_cnt_in  = '0;
      end
   end

   // Only pixels that produce something take a queue slot.
   assign push.valid = accept && (entry.has_data || entry.has_err);
   assign push.entry = entry;

endmodule

// ----- rtl/lse_queue.sv -----
// Short entry queue between the decoder front end and the result back end.
`timescale 1ns / 1ps

module lse_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  lse_pkg::push_type push,
   output logic              space_ok,
   output lse_pkg::head_type head,
   input  logic              pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lse_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign space_ok   = (count_ff != CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && space_ok;
   assign do_pop     = pop && head.valid;

   // Pointer and fill count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ----- rtl/lse_back.sv -----
// Back end: splits each queue entry into one or two result words in an output register.
`timescale 1ns / 1ps

module lse_back (
   input  logic              clock,
   input  logic              reset,
   input  lse_pkg::head_type head,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_message_byte,
   output logic [1:0]        out_status,
   output logic [31:0]       out_message_length,
   output logic              out_last
);

   logic        valid_ff, valid_in;
   logic        second_ff, second_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] length_ff, length_in;
   logic        last_ff, last_in;
   logic        load;
   logic        emit_data;

   // The output register takes a new word whenever it is empty or being drained.
   assign load      = head.valid && (!valid_ff || out_ready);
   assign emit_data = head.entry.has_data && !second_ff;

   always_comb begin
      valid_in  = valid_ff && !out_ready;
      second_in = second_ff;
      pop       = 1'b0;
      byte_in   = byte_ff;
      status_in = status_ff;
      length_in = length_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in  = 1'b1;
         length_in = head.entry.length;
         if (emit_data) begin
            byte_in   = head.entry.data_byte;
            status_in = head.entry.data_status;
            last_in   = head.entry.data_last;
         end else begin
            byte_in   = '0;
            status_in = head.entry.err_status;
            last_in   = 1'b1;
         end
         // An entry with both words stays at the head until its error word is loaded too.
         if (emit_data && head.entry.has_err) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      length_ff <= length_in;
      last_ff   <= last_in;
   end

   assign out_valid          = valid_ff;
   assign out_message_byte   = byte_ff;
   assign out_status         = status_ff;
   assign out_message_length = length_ff;
   assign out_last           = last_ff;

endmodule

// ----- rtl/lsb_stego_extract.sv -----
// Top level of the LSB steganography extractor.
//
//   Channel   Direction  Word
//   req_port  in         one pixel: channel_0..2 and end_of_image
//   rsp_port  out        message_byte, status, message_length, last
//
// One pixel is taken per clock while the entry queue has a free slot.
// Results leave at one word per clock from a registered output while the result
// side is ready; a pixel that yields a byte and an end-of-image error gives two
// result words, byte first. Pixel data is queued, then registered at the output.
// Reset is synchronous and returns the decoder to the header phase.
// A stalled result side fills the QUEUE_DEPTH entry queue, then holds off pixels.
`timescale 1ns / 1ps

module lsb_stego_extract #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   lse_req_if.sink   req_port,
   lse_rsp_if.source rsp_port
);

   lse_pkg::push_type push;
   lse_pkg::head_type head;
   logic              space_ok;
   logic              pop;

   // Decoder front end.
   lse_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_port.valid),
      .in_channel_0    (req_port.channel_0),
      .in_channel_1    (req_port.channel_1),
      .in_channel_2    (req_port.channel_2),
      .in_end_of_image (req_port.end_of_image),
      .space_ok        (space_ok),
      .in_ready        (req_port.ready),
      .push            (push)
   );

   // Entry queue.
   lse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .head     (head),
      .pop      (pop)
   );

   // Result back end.
   lse_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .out_valid          (rsp_port.valid),
      .out_ready          (rsp_port.ready),
      .out_message_byte   (rsp_port.message_byte),
      .out_status         (rsp_port.status),
      .out_message_length (rsp_port.message_length),
      .out_last           (rsp_port.last)
   );

endmodule

// ----- rtl/lse_checker.sv -----
// Port-level checks on the extractor's result channel, bound to the top level.
`timescale 1ns / 1ps

module lse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_message_byte,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_message_length,
   input logic        rsp_last
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // The output is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every status other than a data byte closes the image.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lse_pkg::ST_BYTE |-> rsp_last)
      else $error("non-byte status without last");

   // Empty and short-header results carry no byte and no length.
   a_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lse_pkg::ST_EMPTY || rsp_status == lse_pkg::ST_HDR_SHORT)
      |-> rsp_message_length == '0 && rsp_message_byte == '0)
      else $error("length or byte set on empty or short-header result");

   // A truncation error follows a nonzero header and carries no byte.
   a_trunc_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lse_pkg::ST_TRUNC
      |-> rsp_message_length != '0 && rsp_message_byte == '0)
      else $error("truncation result with zero length or a byte");

endmodule

bind lsb_stego_extract lse_checker u_lse_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_port.valid),
   .rsp_ready          (rsp_port.ready),
   .rsp_message_byte   (rsp_port.message_byte),
   .rsp_status         (rsp_port.status),
   .rsp_message_length (rsp_port.message_length),
   .rsp_last           (rsp_port.last)
);

// ----- test/tb_lsb_stego_extract.sv -----
// Self-checking testbench for lsb_stego_extract: pixel stimulus, decode prediction, checks.
`timescale 1ns / 1ps

module tb_lsb_stego_extract;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 120;

   // One expected result word.
   typedef struct {
      logic [7:0]          msg_byte;
      lse_pkg::status_type status;
      logic [31:0]         msg_len;
      logic                last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lse_req_if pixel_bus ();
   lse_rsp_if result_bus ();

   lsb_stego_extract uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (pixel_bus),
      .rsp_port (result_bus)
   );

   // Decoder state mirrored by the predictor.
   lse_pkg::phase_type dec_phase;
   logic [31:0]        hdr_shift;
   int                 hdr_count;
   logic [31:0]        bytes_left;
   logic [31:0]        latched_len;
   logic [7:0]         acc;
   int                 acc_count;

   result_word_type pending_words[$];
   result_word_type oldest;

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_trigger   = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   always #1 clock = ~clock;

   // Global watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
         $display("tb_lsb_stego_extract failed");
         $finish;
      end
   end

   // Result side: random stalls, plus long hold-offs counted here.
   always @(posedge clock) begin
      if (hold_trigger != hold_served) begin
         hold_served = hold_trigger;
         hold_left   = HOLD_CYCLES;
      end
      if (reset) begin
         result_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         result_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Each accepted result word is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && result_bus.valid && result_bus.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: result word with none expected, expected none actual status %0d",
                     $time, result_bus.status);
            error_count++;
         end else begin
            oldest = pending_words.pop_front();
            compare_field("message_byte", oldest.msg_byte, result_bus.message_byte);
            compare_field("status", oldest.status, result_bus.status);
            compare_field("message_length", oldest.msg_len, result_bus.message_length);
            compare_field("last", oldest.last, result_bus.last);
         end
      end
   end

   function automatic void clear_decoder();
      dec_phase   = lse_pkg::PH_HEADER;
      hdr_shift   = '0;
      hdr_count   = 0;
      bytes_left  = '0;
      latched_len = '0;
      acc         = '0;
      acc_count   = 0;
   endfunction

   function automatic void expect_word(input logic [7:0] b, input lse_pkg::status_type st,
                                       input logic [31:0] len, input logic last);
      result_word_type w;
      w.msg_byte = b;
      w.status   = st;
      w.msg_len  = len;
      w.last     = last;
      pending_words.insert(pending_words.size(), w);
   endfunction

   // Feed one stream bit through the header and message phases.
   function automatic void take_stream_bit(input logic b);
      case (dec_phase)
         lse_pkg::PH_HEADER: begin
            hdr_shift = {hdr_shift[30:0], b};
            hdr_count++;
            if (hdr_count >= lse_pkg::HEADER_BITS) begin
               latched_len = hdr_shift;
               bytes_left  = hdr_shift;
               acc         = '0;
               acc_count   = 0;
               if (hdr_shift == 32'd0) begin
                  dec_phase = lse_pkg::PH_DONE;
                  expect_word(8'h00, lse_pkg::ST_EMPTY, 32'd0, 1'b1);
               end else begin
                  dec_phase = lse_pkg::PH_MESSAGE;
               end
            end
         end
         lse_pkg::PH_MESSAGE: begin
            acc = {acc[6:0], b};
            acc_count++;
            if (acc_count >= lse_pkg::BYTE_BITS) begin
               expect_word(acc, lse_pkg::ST_BYTE, latched_len, bytes_left == 32'd1);
               acc       = '0;
               acc_count = 0;
               bytes_left--;
               if (bytes_left == 32'd0) dec_phase = lse_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // Expected results of one accepted pixel word.
   function automatic void decode_pixel(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic eoi);
      take_stream_bit(c0[0]);
      take_stream_bit(c1[0]);
      take_stream_bit(c2[0]);
      if (eoi) begin
         if (dec_phase == lse_pkg::PH_HEADER) begin
            expect_word(8'h00, lse_pkg::ST_HDR_SHORT, 32'd0, 1'b1);
         end else if (dec_phase == lse_pkg::PH_MESSAGE) begin
            expect_word(8'h00, lse_pkg::ST_TRUNC, latched_len, 1'b1);
         end
         clear_decoder();
      end
   endfunction

   // Offer one pixel word, with random gaps before it, and wait for acceptance.
   task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         pixel_bus.valid <= 1'b0;
         @(posedge clock);
      end
      pixel_bus.valid        <= 1'b1;
      pixel_bus.channel_0    <= c0;
      pixel_bus.channel_1    <= c1;
      pixel_bus.channel_2    <= c2;
      pixel_bus.end_of_image <= eoi;
      @(posedge clock);
      while (!pixel_bus.ready) @(posedge clock);
      decode_pixel(c0, c1, c2, eoi);
   endtask

   task automatic stop_pixels();
      pixel_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One image: the header carries len, later bits are random, the last pixel ends it.
   task automatic send_image(input logic [31:0] len, input int n_pixels, inout int sent);
      logic [7:0] ch[3];
      int         idx;
      for (int k = 0; k < n_pixels; k++) begin
         for (int c = 0; c < 3; c++) begin
            idx = 3 * k + c;
            ch[c] = 8'($urandom_range(255));
            if (idx < 32) ch[c][0] = len[31 - idx];
         end
         send_pixel(ch[0], ch[1], ch[2], k == n_pixels - 1);
         sent++;
      end
   endtask

   // Channel extremes: all-ones header with truncation, all-zero header, one-pixel image.
   task automatic test_extremes();
      for (int k = 0; k < 11; k++) send_pixel(8'hFF, 8'hFF, 8'hFF, k == 10);
      for (int k = 0; k < 11; k++) send_pixel(8'h00, 8'h00, 8'h00, k == 10);
      send_pixel(8'hFE, 8'h7F, 8'h80, 1'b1);
      stop_pixels();
      wait_drain();
   endtask

   // Images of random content, well-formed or truncated, some short, empty, huge or pure noise.
   task automatic test_random_images(input int pixel_goal);
      int          sent;
      int          kind;
      int          need;
      int          j;
      logic [31:0] len;
      sent = 0;
      while (sent < pixel_goal) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            send_image(32'($urandom), $urandom_range(1, 40), sent);
         end else if (kind < 16) begin
            send_image(32'($urandom), $urandom_range(1, 10), sent);
         end else if (kind < 24) begin
            send_image(32'd0, $urandom_range(11, 16), sent);
         end else if (kind < 34) begin
            len = 32'($urandom) | 32'h100;
            send_image(len, $urandom_range(11, 30), sent);
         end else begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            need = (32 + 8 * len + 2) / 3;
            case ($urandom_range(3))
               0: send_image(len, need, sent);
               1: send_image(len, need + $urandom_range(1, 6), sent);
               2: send_image(len, $urandom_range(11, need - 1), sent);
               default: begin
                  // End the image on the pixel that completes an inner byte.
                  if (len >= 2) begin
                     j = $urandom_range(1, len - 1);
                     send_image(len, (32 + 8 * j - 1) / 3 + 1, sent);
                  end else begin
                     send_image(len, need, sent);
                  end
               end
            endcase
         end
      end
      stop_pixels();
      wait_drain();
   endtask

   // Result side held off for a long stretch while pixels keep coming.
   task automatic test_backpressure();
      int sent;
      sent = 0;
      hold_trigger++;
      send_image(32'd20, 70, sent);
      send_image(32'd3, 20, sent);
      stop_pixels();
      wait_drain();
   endtask

   initial begin
      pixel_bus.valid        <= 1'b0;
      pixel_bus.channel_0    <= 8'h00;
      pixel_bus.channel_1    <= 8'h00;
      pixel_bus.channel_2    <= 8'h00;
      pixel_bus.end_of_image <= 1'b0;
      reset                  <= 1'b1;
      clear_decoder();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 6;
      recv_idle_pct = 80;
      test_extremes();
      test_random_images(480);

      send_idle_pct = 80;
      recv_idle_pct = 6;
      test_random_images(420);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_images(450);
      test_backpressure();

      if (error_count == 0) begin
         $display("tb_lsb_stego_extract passed");
      end else begin
         $display("tb_lsb_stego_extract failed");
      end
      $finish;
   end

endmodule
